// ===== rtl/slmpd_pkg.sv =====
package slmpd_pkg;

	localparam int DEF_MAX_SAMPLES = 4096;
	localparam int DEF_SAMPLE_BITS = 16;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam int GMAX_W     = 16;
	localparam int THR_W      = 16;
	localparam int CHAN_W     = 8;
	localparam int WAVE_W     = 32;
	localparam int PNUM_W     = 13;
	localparam int KIND_W     = 2;

	localparam logic [PNUM_W-1:0] PEAK_COUNT_MAX = '1;

	localparam logic [CFG_IDX_W-1:0] REG_GLOBAL_MAX     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PEAK_THRESHOLD = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_ID     = 2'd2;

	localparam logic [KIND_W-1:0] KIND_NONE = 2'd0;
	localparam logic [KIND_W-1:0] KIND_MAX  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_MIN  = 2'd2;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic              peak_valid;
		logic [PNUM_W-1:0] peak_number;
	} peak_info_t;

endpackage

// ===== rtl/slmpd_track.sv =====
module slmpd_track #(
	parameter int MAX_SAMPLES = slmpd_pkg::DEF_MAX_SAMPLES,
	parameter int SAMPLE_BITS = slmpd_pkg::DEF_SAMPLE_BITS
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  fire,
	input  logic [SAMPLE_BITS-1:0]                filtered,
	input  logic [SAMPLE_BITS-1:0]                raw,
	input  logic [slmpd_pkg::WAVE_W-1:0]          wavelength,
	input  logic                                  start,
	input  logic [slmpd_pkg::GMAX_W-1:0]          global_max,
	input  logic [slmpd_pkg::THR_W-1:0]           peak_threshold,
	output logic                                  has_result,
	output logic [$clog2(MAX_SAMPLES)-1:0]        sample_index,
	output logic signed [SAMPLE_BITS:0]           slope,
	output slmpd_pkg::peak_info_t                 info,
	output logic [slmpd_pkg::WAVE_W-1:0]          wavelength_d,
	output logic [SAMPLE_BITS-1:0]                raw_d
);
	import slmpd_pkg::*;

	localparam int CW = $clog2(MAX_SAMPLES + 1);
	localparam int IW = $clog2(MAX_SAMPLES);
	localparam int SW = SAMPLE_BITS + 1;
	localparam int DW = (SAMPLE_BITS > GMAX_W) ? SAMPLE_BITS : GMAX_W;

	logic [SAMPLE_BITS-1:0] last_filtered_q;
	logic signed [SW-1:0]   last_slope_q;
	logic [SAMPLE_BITS-1:0] delayed_raw_q;
	logic [WAVE_W-1:0]      delayed_wave_q;
	logic [CW-1:0]          sample_count_q;
	logic [PNUM_W-1:0]      peak_count_q;

	logic [CW-1:0]        cnt_eff;
	logic [CW-1:0]        cnt_m1;
	logic [PNUM_W-1:0]    pc_eff;
	logic [PNUM_W-1:0]    pc_next;
	logic                 over;
	logic                 first;
	logic signed [SW-1:0] s;
	logic                 s_neg, s_zero, s_pos;
	logic                 p_neg, p_zero, p_pos;
	logic                 is_max, is_min;
	logic [DW-1:0]        gm_ext, raw_ext, thr_ext, gm_delta;
	logic                 in_range;

	always_comb begin
		cnt_eff  = start ? '0 : sample_count_q;
		pc_eff   = start ? '0 : peak_count_q;
		over     = cnt_eff >= CW'(MAX_SAMPLES);
		first    = cnt_eff == '0;
		cnt_m1   = cnt_eff - CW'(1);

		s        = signed'({1'b0, filtered}) - signed'({1'b0, last_filtered_q});
		s_neg    = s[SW-1];
		s_zero   = s == '0;
		s_pos    = !s_neg && !s_zero;
		p_neg    = last_slope_q[SW-1];
		p_zero   = last_slope_q == '0;
		p_pos    = !p_neg && !p_zero;

		is_max   = (cnt_m1[IW-1:0] != '0) &&
			(((s_neg || s_zero) && p_pos) || (s_neg && p_zero));
		is_min   = (cnt_m1[IW-1:0] != '0) && !is_max &&
			((s_pos && (p_neg || p_zero)) || (s_zero && p_neg));

		gm_ext   = DW'(global_max);
		raw_ext  = DW'(delayed_raw_q);
		thr_ext  = DW'(peak_threshold);
		gm_delta = (gm_ext >= raw_ext) ? (gm_ext - raw_ext) : (raw_ext - gm_ext);
		in_range = is_max && (gm_delta < thr_ext);

		pc_next  = (in_range && (pc_eff != PEAK_COUNT_MAX)) ? pc_eff + PNUM_W'(1) : pc_eff;

		has_result       = !over && !first;
		sample_index     = cnt_m1[IW-1:0];
		slope            = s;
		info.kind        = is_max ? KIND_MAX : (is_min ? KIND_MIN : KIND_NONE);
		info.peak_valid  = in_range;
		info.peak_number = in_range ? pc_next : '0;
		wavelength_d     = delayed_wave_q;
		raw_d            = delayed_raw_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_count_q <= '0;
			peak_count_q   <= '0;
		end else if (fire && !over) begin
			sample_count_q <= cnt_eff + CW'(1);
			peak_count_q   <= first ? pc_eff : pc_next;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && !over) begin
			last_filtered_q <= filtered;
			last_slope_q    <= first ? '0 : s;
			delayed_raw_q   <= raw;
			delayed_wave_q  <= wavelength;
		end
	end

endmodule

// ===== rtl/spectrum_local_max_peak_detect_unit.sv =====
// Channel   | Handshake               | Payload
// ----------+-------------------------+--------------------------------------------
// in        | in_valid / in_ready     | filtered_sample, raw_sample,
//           |                         | wavelength_code, spectrum_start
// out       | out_valid / out_ready   | sample_index, slope, extremum_kind,
//           |                         | peak_valid, peak_number, peak_channel,
//           |                         | peak_wavelength, peak_intensity
// cfg       | cfg_wr_en               | cfg_index, cfg_data
//
// One transaction per cycle unless stalled: input reg, one subtract/compare stage, result reg.
// A completing input transaction reaches out_valid through the input and result registers.
// First sample of a spectrum and samples past MAX_SAMPLES leave the input stage without a result.
// A stalled result register holds a result-bearing transaction in the input stage;
// in_ready is low only while the input stage holds a transaction that cannot advance.
// arst_n clears valids, sample count, peak count and the configuration registers.
module spectrum_local_max_peak_detect_unit #(
	parameter int MAX_SAMPLES = slmpd_pkg::DEF_MAX_SAMPLES,
	parameter int SAMPLE_BITS = slmpd_pkg::DEF_SAMPLE_BITS
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic [SAMPLE_BITS-1:0]                filtered_sample,
	input  logic [SAMPLE_BITS-1:0]                raw_sample,
	input  logic [slmpd_pkg::WAVE_W-1:0]          wavelength_code,
	input  logic                                  spectrum_start,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic [$clog2(MAX_SAMPLES)-1:0]        sample_index,
	output logic signed [SAMPLE_BITS:0]           slope,
	output logic [slmpd_pkg::KIND_W-1:0]          extremum_kind,
	output logic                                  peak_valid,
	output logic [slmpd_pkg::PNUM_W-1:0]          peak_number,
	output logic [slmpd_pkg::CHAN_W-1:0]          peak_channel,
	output logic [slmpd_pkg::WAVE_W-1:0]          peak_wavelength,
	output logic [SAMPLE_BITS-1:0]                peak_intensity,
	input  logic                                  cfg_wr_en,
	input  logic [slmpd_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [slmpd_pkg::CFG_DATA_W-1:0]      cfg_data
);
	import slmpd_pkg::*;

	localparam int IW = $clog2(MAX_SAMPLES);

	logic [GMAX_W-1:0] global_max_q;
	logic [THR_W-1:0]  peak_threshold_q;
	logic [CHAN_W-1:0] channel_id_q;

	logic                   valid_s1;
	logic [SAMPLE_BITS-1:0] filtered_s1;
	logic [SAMPLE_BITS-1:0] raw_s1;
	logic [WAVE_W-1:0]      wave_s1;
	logic                   start_s1;
	logic                   advance_s1;

	logic                   has_result;
	logic [IW-1:0]          idx_c;
	logic signed [SAMPLE_BITS:0] slope_c;
	peak_info_t             info_c;
	logic [WAVE_W-1:0]      wave_d;
	logic [SAMPLE_BITS-1:0] raw_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			global_max_q     <= '0;
			peak_threshold_q <= '0;
			channel_id_q     <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_GLOBAL_MAX:     global_max_q     <= cfg_data[GMAX_W-1:0];
				REG_PEAK_THRESHOLD: peak_threshold_q <= cfg_data[THR_W-1:0];
				REG_CHANNEL_ID:     channel_id_q     <= cfg_data[CHAN_W-1:0];
				default: ;
			endcase
		end
	end

	assign advance_s1 = valid_s1 && (!has_result || !out_valid || out_ready);
	assign in_ready   = !valid_s1 || advance_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			filtered_s1 <= filtered_sample;
			raw_s1      <= raw_sample;
			wave_s1     <= wavelength_code;
			start_s1    <= spectrum_start;
		end
	end

	slmpd_track #(
		.MAX_SAMPLES (MAX_SAMPLES),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_track (
		.clk            (clk),
		.arst_n         (arst_n),
		.fire           (advance_s1),
		.filtered       (filtered_s1),
		.raw            (raw_s1),
		.wavelength     (wave_s1),
		.start          (start_s1),
		.global_max     (global_max_q),
		.peak_threshold (peak_threshold_q),
		.has_result     (has_result),
		.sample_index   (idx_c),
		.slope          (slope_c),
		.info           (info_c),
		.wavelength_d   (wave_d),
		.raw_d          (raw_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance_s1 && has_result) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance_s1 && has_result) begin
			sample_index    <= idx_c;
			slope           <= slope_c;
			extremum_kind   <= info_c.kind;
			peak_valid      <= info_c.peak_valid;
			peak_number     <= info_c.peak_number;
			peak_channel    <= info_c.peak_valid ? channel_id_q : '0;
			peak_wavelength <= wave_d;
			peak_intensity  <= raw_d;
		end
	end

`ifndef SYNTHESIS
	a_peak_is_max: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && peak_valid |-> extremum_kind == KIND_MAX)
		else $error("peak reported on a non-maximum");

	a_peak_number_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && peak_valid |-> peak_number != '0)
		else $error("accepted peak carries number zero");

	a_no_peak_fields_clear: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !peak_valid |-> peak_number == '0 && peak_channel == '0)
		else $error("peak number or channel set without a peak");

	a_index_zero_none: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && sample_index == '0 |-> extremum_kind == KIND_NONE)
		else $error("index zero classified as extremum");

	a_stage_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance_s1 |=> valid_s1 && $stable(filtered_s1) && $stable(start_s1))
		else $error("input stage lost a stalled transaction");
`endif

endmodule

// ===== tb/sv/testbench.sv =====
module testbench;
	import slmpd_pkg::*;

	localparam int MAX_SAMPLES = DEF_MAX_SAMPLES;
	localparam int SAMPLE_BITS = DEF_SAMPLE_BITS;
	localparam int IDX_W       = $clog2(MAX_SAMPLES);
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	typedef enum {READY_ALWAYS, READY_RANDOM, READY_PATTERN} ready_mode_t;

	typedef struct {
		logic [IDX_W-1:0]       idx;
		logic [SAMPLE_BITS:0]   slope;
		logic [KIND_W-1:0]      kind;
		logic                   is_peak;
		logic [PNUM_W-1:0]      number;
		logic [CHAN_W-1:0]      chan;
		logic [WAVE_W-1:0]      wave;
		logic [SAMPLE_BITS-1:0] inten;
	} sample_class_t;

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic [SAMPLE_BITS-1:0] filtered_sample;
	logic [SAMPLE_BITS-1:0] raw_sample;
	logic [WAVE_W-1:0] wavelength_code;
	logic spectrum_start;
	logic out_valid;
	logic out_ready;
	logic [IDX_W-1:0] sample_index;
	logic signed [SAMPLE_BITS:0] slope;
	logic [KIND_W-1:0] extremum_kind;
	logic peak_valid;
	logic [PNUM_W-1:0] peak_number;
	logic [CHAN_W-1:0] peak_channel;
	logic [WAVE_W-1:0] peak_wavelength;
	logic [SAMPLE_BITS-1:0] peak_intensity;
	logic cfg_wr_en;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	spectrum_local_max_peak_detect_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.filtered_sample(filtered_sample),
		.raw_sample(raw_sample),
		.wavelength_code(wavelength_code),
		.spectrum_start(spectrum_start),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.sample_index(sample_index),
		.slope(slope),
		.extremum_kind(extremum_kind),
		.peak_valid(peak_valid),
		.peak_number(peak_number),
		.peak_channel(peak_channel),
		.peak_wavelength(peak_wavelength),
		.peak_intensity(peak_intensity),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #10 clk = ~clk;

	sample_class_t pending_classes[$];
	int err_count = 0;

	logic [GMAX_W-1:0] pred_gmax = '0;
	logic [THR_W-1:0] pred_thr = '0;
	logic [CHAN_W-1:0] pred_chan = '0;

	logic [SAMPLE_BITS-1:0] prev_filt = '0;
	logic [SAMPLE_BITS-1:0] held_raw = '0;
	logic [WAVE_W-1:0] held_wave = '0;
	int prev_slope = 0;
	int seen_count = 0;
	int peak_total = 0;

	int gap_max = 0;
	int burst_max = 1;
	int burst_left = 0;
	ready_mode_t ready_mode = READY_ALWAYS;
	int hold_req = 0;
	int hold_left = 0;
	int pat_cnt = 0;

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		err_count++;
		if (err_count <= 50)
			$display("mismatch %s: got %0h want %0h at %0t", what, got, want, $time);
	endtask

	task automatic classify_sample(logic [SAMPLE_BITS-1:0] filt, logic [SAMPLE_BITS-1:0] raw,
		logic [WAVE_W-1:0] wave, logic start);
		sample_class_t res;
		int s;
		int gm_delta;
		if (start) begin
			seen_count = 0;
			peak_total = 0;
		end
		if (seen_count >= MAX_SAMPLES)
			return;
		if (seen_count == 0) begin
			prev_filt = filt;
			held_raw = raw;
			held_wave = wave;
			prev_slope = 0;
			seen_count = 1;
			return;
		end
		s = int'(filt) - int'(prev_filt);
		res.idx = IDX_W'(seen_count - 1);
		res.slope = s[SAMPLE_BITS:0];
		res.kind = KIND_NONE;
		res.is_peak = 1'b0;
		res.number = '0;
		res.chan = '0;
		res.wave = held_wave;
		res.inten = held_raw;
		if (seen_count != 1) begin
			if ((s <= 0 && prev_slope > 0) || (s < 0 && prev_slope == 0)) begin
				res.kind = KIND_MAX;
				gm_delta = int'(pred_gmax) - int'(held_raw);
				if (gm_delta < 0)
					gm_delta = -gm_delta;
				if (gm_delta < int'(pred_thr)) begin
					if (peak_total < int'(PEAK_COUNT_MAX))
						peak_total++;
					res.is_peak = 1'b1;
					res.number = PNUM_W'(peak_total);
					res.chan = pred_chan;
				end
			end else if ((s > 0 && prev_slope <= 0) || (s == 0 && prev_slope < 0)) begin
				res.kind = KIND_MIN;
			end
		end
		pending_classes.insert(pending_classes.size(), res);
		prev_slope = s;
		prev_filt = filt;
		held_raw = raw;
		held_wave = wave;
		seen_count++;
	endtask

	always @(posedge clk) begin
		sample_class_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_classes.size() == 0) begin
				report_mismatch("unexpected result, index", sample_index, 0);
			end else begin
				want = pending_classes.pop_front();
				if (sample_index !== want.idx)
					report_mismatch("sample_index", sample_index, want.idx);
				if (slope !== want.slope)
					report_mismatch("slope", slope, want.slope);
				if (extremum_kind !== want.kind)
					report_mismatch("extremum_kind", extremum_kind, want.kind);
				if (peak_valid !== want.is_peak)
					report_mismatch("peak_valid", peak_valid, want.is_peak);
				if (peak_number !== want.number)
					report_mismatch("peak_number", peak_number, want.number);
				if (peak_channel !== want.chan)
					report_mismatch("peak_channel", peak_channel, want.chan);
				if (peak_wavelength !== want.wave)
					report_mismatch("peak_wavelength", peak_wavelength, want.wave);
				if (peak_intensity !== want.inten)
					report_mismatch("peak_intensity", peak_intensity, want.inten);
			end
		end
	end

	always @(negedge clk) begin
		if (hold_req != 0) begin
			hold_left = hold_req;
			hold_req = 0;
		end
		pat_cnt++;
		if (hold_left != 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			case (ready_mode)
				READY_ALWAYS: out_ready <= 1'b1;
				READY_RANDOM: out_ready <= ($urandom_range(0, 99) < 60);
				default: out_ready <= ((pat_cnt % 13) < 7);
			endcase
		end
	end

	task automatic send_sample(logic [SAMPLE_BITS-1:0] filt, logic [SAMPLE_BITS-1:0] raw,
		logic [WAVE_W-1:0] wave, logic start);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, burst_max);
			gap = (gap_max != 0) ? $urandom_range(0, gap_max) : 0;
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		filtered_sample <= filt;
		raw_sample <= raw;
		wavelength_code <= wave;
		spectrum_start <= start;
		do @(posedge clk); while (!in_ready);
		classify_sample(filt, raw, wave, start);
		@(negedge clk);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pending_classes.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic set_config(logic [CFG_DATA_W-1:0] gmax, logic [CFG_DATA_W-1:0] thr,
		logic [CFG_DATA_W-1:0] chan);
		cfg_wr_en <= 1'b1;
		cfg_index <= REG_GLOBAL_MAX;
		cfg_data <= gmax;
		@(negedge clk);
		cfg_index <= REG_PEAK_THRESHOLD;
		cfg_data <= thr;
		@(negedge clk);
		cfg_index <= REG_CHANNEL_ID;
		cfg_data <= chan;
		@(negedge clk);
		cfg_index <= REG_UNUSED;
		cfg_data <= ~gmax;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		pred_gmax = gmax;
		pred_thr = thr;
		pred_chan = chan[CHAN_W-1:0];
	endtask

	function automatic logic [SAMPLE_BITS-1:0] pick_raw();
		int r;
		int sgn;
		int off;
		case ($urandom_range(0, 3))
			0: r = int'(pred_gmax);
			1: begin
				sgn = $urandom_range(0, 1) ? 1 : -1;
				off = int'(pred_thr) - 1 + int'($urandom_range(0, 2));
				r = int'(pred_gmax) + sgn * off;
			end
			default: r = int'($urandom_range(0, 65535));
		endcase
		if (r < 0)
			r = 0;
		if (r > 65535)
			r = 65535;
		return r[SAMPLE_BITS-1:0];
	endfunction

	task automatic send_spectrum(int len, bit noisy, bit with_start);
		int f;
		int dir;
		int step;
		logic [WAVE_W-1:0] w;
		f = $urandom_range(0, 65535);
		w = $urandom;
		dir = 1;
		for (int i = 0; i < len; i++) begin
			if (noisy) begin
				send_sample(SAMPLE_BITS'($urandom_range(0, 65535)),
					SAMPLE_BITS'($urandom_range(0, 65535)), $urandom,
					(i == 0 && with_start) || $urandom_range(0, 19) == 0);
			end else begin
				if ($urandom_range(0, 4) == 0)
					dir = -dir;
				step = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 400));
				f += dir * step;
				if (f < 0)
					f = 0;
				if (f > 65535)
					f = 65535;
				w += $urandom_range(1, 1000);
				send_sample(f[SAMPLE_BITS-1:0], pick_raw(), w, i == 0 && with_start);
			end
		end
	endtask

	task automatic test_no_start_after_reset();
		send_sample(16'd5, 16'd0, 32'd100, 1'b0);
		send_sample(16'd10, 16'd0, 32'd101, 1'b0);
		send_sample(16'd3, 16'd0, 32'd102, 1'b0);
		send_sample(16'd3, 16'd0, 32'd103, 1'b0);
		send_sample(16'd8, 16'd0, 32'd104, 1'b0);
		send_sample(16'd1, 16'd0, 32'd105, 1'b0);
		wait_drained();
	endtask

	task automatic test_directed();
		set_config(16'd1000, 16'd50, 16'h00A5);
		send_sample(16'd100, 16'd1000, 32'd0, 1'b1);
		send_sample(16'd200, 16'd1049, 32'hFFFF_FFFF, 1'b0);
		send_sample(16'd300, 16'd951, 32'd1, 1'b0);
		send_sample(16'd300, 16'd1050, 32'd2, 1'b0);
		send_sample(16'd200, 16'd950, 32'd3, 1'b0);
		send_sample(16'd200, 16'd1000, 32'd4, 1'b0);
		send_sample(16'd250, 16'd0, 32'd5, 1'b0);
		send_sample(16'd250, 16'd65535, 32'd6, 1'b0);
		send_sample(16'd150, 16'd1000, 32'd7, 1'b0);
		send_sample(16'd0, 16'd1001, 32'd8, 1'b0);
		send_sample(16'd65535, 16'd999, 32'd9, 1'b0);
		send_sample(16'd0, 16'd1000, 32'd10, 1'b0);
		send_sample(16'd0, 16'd1000, 32'd11, 1'b0);
		send_sample(16'd65535, 16'd1000, 32'd12, 1'b0);
		send_sample(16'd65535, 16'd1000, 32'd13, 1'b0);
		send_sample(16'd500, 16'd1000, 32'hAAAA_5555, 1'b1);
		send_sample(16'd400, 16'd1000, 32'h5555_AAAA, 1'b0);
		send_sample(16'd450, 16'd1020, 32'd20, 1'b0);
		send_sample(16'd300, 16'd980, 32'd21, 1'b0);
		send_sample(16'd7, 16'd1000, 32'd30, 1'b1);
		send_sample(16'd8, 16'd1000, 32'd31, 1'b1);
		send_sample(16'd9, 16'd1000, 32'd32, 1'b0);
		wait_drained();
	endtask

	task automatic test_back_pressure();
		set_config(16'd20000, 16'd30000, 16'h3C3C);
		gap_max = 0;
		burst_max = 1;
		ready_mode = READY_ALWAYS;
		hold_req = 300;
		send_spectrum(80, 1'b0, 1'b1);
		wait_drained();
	endtask

	task automatic test_random_phases();
		int sent;
		int len;
		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0: set_config(16'd0, 16'd0, 16'd0);
				1: set_config(16'hFFFF, 16'hFFFF, 16'hFFFF);
				2: set_config(16'd0, 16'hFFFF, 16'h00FF);
				3: set_config(16'hFFFF, 16'd1, 16'hFF00);
				default: set_config(CFG_DATA_W'($urandom_range(0, 65535)),
					CFG_DATA_W'($urandom_range(0, 2000)),
					CFG_DATA_W'($urandom_range(0, 65535)));
			endcase
			case (ph % 4)
				0: begin
					gap_max = 0;
					ready_mode = READY_ALWAYS;
				end
				1: begin
					gap_max = 3;
					burst_max = 6;
					ready_mode = READY_RANDOM;
				end
				2: begin
					gap_max = 8;
					burst_max = 12;
					ready_mode = READY_PATTERN;
				end
				default: begin
					gap_max = 2;
					burst_max = 3;
					ready_mode = READY_RANDOM;
				end
			endcase
			sent = 0;
			while (sent < 150) begin
				len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 30);
				send_spectrum(len, $urandom_range(0, 4) == 0, $urandom_range(0, 9) != 0);
				sent += len;
			end
			wait_drained();
		end
	endtask

	task automatic test_size_limit();
		set_config(16'd30000, 16'd2, 16'h5A3C);
		gap_max = 0;
		ready_mode = READY_ALWAYS;
		for (int i = 0; i < MAX_SAMPLES + 20; i++)
			send_sample(i[0] ? 16'd40000 : 16'd100,
				SAMPLE_BITS'(16'd29999 + $urandom_range(0, 2)), WAVE_W'(i), i == 0);
		gap_max = 3;
		burst_max = 4;
		ready_mode = READY_RANDOM;
		send_spectrum(12, 1'b0, 1'b1);
		wait_drained();
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		filtered_sample = '0;
		raw_sample = '0;
		wavelength_code = '0;
		spectrum_start = 1'b0;
		out_ready = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = REG_GLOBAL_MAX;
		cfg_data = '0;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_no_start_after_reset();
		test_directed();
		test_back_pressure();
		test_random_phases();
		test_size_limit();
		wait_drained();
		repeat (10) @(negedge clk);
		if (err_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	initial begin
		#12_000_000;
		$display("== FAIL ==");
		$finish;
	end

endmodule
